>>> hw/rtl/ang_pkg.sv
// ----------------------------------------------------------------------------
// ang_pkg: shared definitions for the audio noise gate
// sample width, fixed-point constants, register indexes, control word
// layout and the microcode program of the sequencer
// ----------------------------------------------------------------------------
package ang_pkg;

  // sample width, Q1.(SAMPLE_BITS-1)
  localparam int SAMPLE_BITS = 16;

  // scaling of |x| to Q1.15
  localparam int DOWN_SHIFT = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int UP_SHIFT   = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

  // shared multiplier: 18-bit signed a operand, b wide enough for a sample or 17 bits
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = ((SAMPLE_BITS > 17) ? SAMPLE_BITS : 17) + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // envelope accumulator, a 33-bit and a 32-bit product summed
  localparam int ACC_W = 34;

  localparam logic [15:0] UNITY_Q15 = 16'h8000;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEVEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLLOFF_FACTOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF   = 3'd4;

  // register reset values
  localparam logic [15:0] RST_CLOSE_THRESHOLD = 16'd3277;
  localparam logic [15:0] RST_OPEN_LEVEL      = 16'd16384;
  localparam logic [15:0] RST_ROLLOFF_FACTOR  = 16'd8520;
  localparam logic [15:0] RST_ATTACK_COEFF    = 16'd41373;
  localparam logic [15:0] RST_RELEASE_COEFF   = 16'd50;

  // program counter
  localparam int STEP_W = 2;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_ENV_DECAY = 2'd0;
  localparam step_t STEP_ATTACK    = 2'd1;
  localparam step_t STEP_GATE      = 2'd2;
  localparam step_t STEP_OUTPUT    = 2'd3;

  typedef enum logic [1:0] {
    A_ENV     = 2'd0,
    A_ATTACK  = 2'd1,
    A_PREV    = 2'd2,
    A_GAIN    = 2'd3
  } a_sel_t;

  typedef enum logic [1:0] {
    B_INV_RC  = 2'd0,
    B_RISE    = 2'd1,
    B_ROLLOFF = 2'd2,
    B_SAMPLE  = 2'd3
  } b_sel_t;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_NO_INPUT = 2'd1,
    COND_OUT_BUSY = 2'd2
  } cond_t;

  typedef struct packed {
    logic   take_in;   // input request may be accepted in this step
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   acc_ld;    // load product into accumulator
    logic   env_wr;    // accumulate and update envelope
    logic   gate_wr;   // gate decision, update gain and state
    logic   out_wr;    // write result register
    cond_t  cond;      // jump condition
    step_t  target;    // jump target when condition holds
  } ctrl_t;

  // microcode table, one control word per step
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '0;
    case (step)
      STEP_ENV_DECAY: begin
        w.take_in = 1'b1;
        w.a_sel   = A_ENV;
        w.b_sel   = B_INV_RC;
        w.acc_ld  = 1'b1;
        w.cond    = COND_NO_INPUT;
        w.target  = STEP_ENV_DECAY;
      end
      STEP_ATTACK: begin
        w.a_sel   = A_ATTACK;
        w.b_sel   = B_RISE;
        w.env_wr  = 1'b1;
        w.cond    = COND_NONE;
        w.target  = STEP_GATE;
      end
      STEP_GATE: begin
        w.a_sel   = A_PREV;
        w.b_sel   = B_ROLLOFF;
        w.gate_wr = 1'b1;
        w.cond    = COND_NONE;
        w.target  = STEP_OUTPUT;
      end
      STEP_OUTPUT: begin
        w.a_sel   = A_GAIN;
        w.b_sel   = B_SAMPLE;
        w.out_wr  = 1'b1;
        w.cond    = COND_OUT_BUSY;
        w.target  = STEP_OUTPUT;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/ang_seq.sv
// ----------------------------------------------------------------------------
// ang_seq: microcode sequencer
// step counter, control word fetch and conditional jumps
// ----------------------------------------------------------------------------
module ang_seq
  import ang_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_busy,
  output ctrl_t ctrl
);

  step_t step_r;
  step_t step_nxt;
  logic  jump;

  assign ctrl = ucode_rom(step_r);

  always_comb begin
    case (ctrl.cond)
      COND_NONE:     jump = 1'b0;
      COND_NO_INPUT: jump = !in_valid;
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b0;
    endcase
    step_nxt = jump ? ctrl.target : step_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_ENV_DECAY;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> hw/rtl/ang_datapath.sv
// ----------------------------------------------------------------------------
// ang_datapath: gate datapath
// configuration registers, shared multiplier, envelope accumulator,
// gate state and result register
// ----------------------------------------------------------------------------
module ang_datapath
  import ang_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctrl_t                         ctrl,
  input  logic                          in_accept,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          out_stall,
  output logic                          out_busy,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic [15:0]                   out_gain_now,
  output logic                          out_gate_open
);

  // configuration
  logic [15:0] close_thr_r, open_lvl_r, rolloff_r, attack_r, release_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_thr_r <= RST_CLOSE_THRESHOLD;
      open_lvl_r  <= RST_OPEN_LEVEL;
      rolloff_r   <= RST_ROLLOFF_FACTOR;
      attack_r    <= RST_ATTACK_COEFF;
      release_r   <= RST_RELEASE_COEFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CLOSE_THRESHOLD: close_thr_r <= cfg_wdata;
        CFG_OPEN_LEVEL:      open_lvl_r  <= cfg_wdata;
        CFG_ROLLOFF_FACTOR:  rolloff_r   <= cfg_wdata;
        CFG_ATTACK_COEFF:    attack_r    <= cfg_wdata;
        CFG_RELEASE_COEFF:   release_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample capture and magnitude in Q1.15
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [15:0]                   mag15_r;
  logic [SAMPLE_BITS:0]          x_ext;
  logic [SAMPLE_BITS:0]          magw;
  logic [SAMPLE_BITS+16:0]       mag_wide;

  assign x_ext    = {in_sample_in[SAMPLE_BITS-1], in_sample_in};
  assign magw     = in_sample_in[SAMPLE_BITS-1] ? -x_ext : x_ext;
  assign mag_wide = ({16'b0, magw} << UP_SHIFT) >> DOWN_SHIFT;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r     <= in_sample_in;
      mag15_r <= mag_wide[15:0];
    end
  end

  // state
  logic [15:0]      env_r, env_nxt;
  logic [15:0]      gain_r, gain_nxt;
  logic             open_r, open_nxt;
  logic [ACC_W-1:0] acc_r;

  // shared multiplier
  logic [16:0]               inv_rc;
  logic [15:0]               rise;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  assign inv_rc = 17'h10000 - {1'b0, release_r};
  assign rise   = (mag15_r > env_r) ? mag15_r - env_r : 16'd0;

  always_comb begin
    case (ctrl.a_sel)
      A_ENV:    mul_a = {2'b0, env_r};
      A_ATTACK: mul_a = {2'b0, attack_r};
      A_PREV:   mul_a = {2'b0, gain_r};
      A_GAIN:   mul_a = {2'b0, gain_r};
      default:  mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_INV_RC:  mul_b = {{(MUL_B_W-17){1'b0}}, inv_rc};
      B_RISE:    mul_b = {{(MUL_B_W-16){1'b0}}, rise};
      B_ROLLOFF: mul_b = {{(MUL_B_W-16){1'b0}}, rolloff_r};
      B_SAMPLE:  mul_b = {{(MUL_B_W-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
      default:   mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  // envelope accumulate and saturate
  logic [ACC_W-1:0]  env_sum;
  logic [ACC_W-17:0] env_full;

  assign env_sum  = acc_r + prod[ACC_W-1:0];
  assign env_full = env_sum[ACC_W-1:16];

  always_comb begin
    env_nxt = env_r;
    if (ctrl.env_wr) begin
      if (env_full > (ACC_W-16)'(UNITY_Q15)) begin
        env_nxt = UNITY_Q15;
      end else begin
        env_nxt = env_full[15:0];
      end
    end
  end

  // gate decision with hysteresis
  logic [15:0] decayed;

  assign decayed = prod[31:16];

  always_comb begin
    gain_nxt = gain_r;
    open_nxt = open_r;
    if (ctrl.gate_wr) begin
      if (open_r) begin
        if (env_r < close_thr_r) begin
          gain_nxt = decayed;
          open_nxt = 1'b0;
        end else begin
          gain_nxt = UNITY_Q15;
        end
      end else if (env_r < open_lvl_r) begin
        gain_nxt = decayed;
      end else if (env_r > open_lvl_r) begin
        gain_nxt = UNITY_Q15;
        open_nxt = 1'b1;
      end else begin
        gain_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= 16'd0;
      gain_r <= UNITY_Q15;
      open_r <= 1'b1;
    end else begin
      env_r  <= env_nxt;
      gain_r <= gain_nxt;
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_ld) begin
      acc_r <= prod[ACC_W-1:0];
    end
  end

  // result register, floor of gain * x / 32768
  logic signed [PROD_W-1:0] y_full;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_load;

  assign y_full   = prod >>> 15;
  assign out_busy = out_valid_r && out_stall;
  assign out_load = ctrl.out_wr && !out_busy;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_out <= y_full[SAMPLE_BITS-1:0];
      out_gain_now   <= gain_r;
      out_gate_open  <= open_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/audio_noise_gate.sv
// ----------------------------------------------------------------------------
// audio_noise_gate: noise gate with hysteresis
// envelope follower, two-state gate with geometric gain decay, one result
// per sample, run by a four-step microcode program on one shared multiplier
// ----------------------------------------------------------------------------
// For each sample request the sequencer steps through a four-word program
// (envelope decay, attack, gain decay with gate decision, output scaling),
// one multiply per step on a single shared multiplier, and that program
// sets the rate. A new sample is taken in the first step only, so the next
// sample waits until the program is back at that step. The result register
// frees the datapath from the output side; the last step holds only while
// an earlier result is still waiting and out_stall is high. Envelope and
// gain are unsigned Q1.15 (32768 is unity), coefficients are Q0.16, samples
// are SAMPLE_BITS-wide two's complement. Configuration writes should be done
// while no sample is in flight.
// ----------------------------------------------------------------------------
module audio_noise_gate
  import ang_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic [15:0]                   out_gain_now,
  output logic                          out_gate_open,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  ctrl_t ctrl;
  logic  out_busy;
  logic  in_accept;

  // input is taken only in the first program step
  assign in_stall  = !ctrl.take_in;
  assign in_accept = in_valid && !in_stall;

  // step counter and microcode table
  ang_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  // multiplier, envelope, gate state and result register
  ang_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_accept      (in_accept),
    .in_sample_in   (in_sample_in),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_stall      (out_stall),
    .out_busy       (out_busy),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .out_gain_now   (out_gain_now),
    .out_gate_open  (out_gate_open)
  );

  // after a request is taken the program runs on, no second request next cycle
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input request accepted in two consecutive cycles");

  // a fresh result follows its request through the attack, gate and output steps and the result register
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 4))
    else $error("result appeared without matching request");

  // an open gate always passes at unity gain
  a_open_unity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gate_open |-> out_gain_now == UNITY_Q15)
    else $error("open gate with non-unity gain");

endmodule

>>> sim/gate_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gate_checker: result checker for the audio noise gate
// follows register writes and sample requests, predicts each gated result
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module gate_checker
  import ang_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic [15:0]                   out_gain_now,
  input  logic                          out_gate_open,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [15:0]                   cfg_wdata,
  output int                            mismatches,
  output int                            pending,
  output int                            results_seen
);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [15:0]                   gain;
    logic                          is_open;
  } gated_t;

  // register copies
  logic [15:0] close_lvl, open_lvl, roll_f, atk_c, rel_c;

  // gate state
  logic [15:0] env_lvl;
  logic [15:0] last_gain;
  logic        gate_up;

  gated_t gated_q[$];
  gated_t want;
  int     errs;
  int     seen;

  function automatic gated_t gate_step(input logic signed [SAMPLE_BITS-1:0] x);
    gated_t r;
    longint xs, mag, lvl, rise, acc, decayed, gain, prod;
    xs   = longint'(x);
    mag  = (xs < 0) ? -xs : xs;
    lvl  = (mag >>> DOWN_SHIFT) << UP_SHIFT;
    rise = (lvl > longint'(env_lvl)) ? lvl - longint'(env_lvl) : 0;
    acc  = longint'(env_lvl) * (65536 - longint'(rel_c)) + longint'(atk_c) * rise;
    acc  = acc >>> 16;
    if (acc > longint'(UNITY_Q15))
      acc = longint'(UNITY_Q15);
    env_lvl = acc[15:0];
    decayed = (longint'(last_gain) * longint'(roll_f)) >>> 16;
    if (gate_up) begin
      if (env_lvl < close_lvl) begin
        gain    = decayed;
        gate_up = 1'b0;
      end else begin
        gain = longint'(UNITY_Q15);
      end
    end else if (env_lvl < open_lvl) begin
      gain = decayed;
    end else if (env_lvl > open_lvl) begin
      gain    = longint'(UNITY_Q15);
      gate_up = 1'b1;
    end else begin
      gain = 0;
    end
    last_gain = gain[15:0];
    // arithmetic shift floors toward minus infinity
    prod      = (gain * xs) >>> 15;
    r.sample  = prod[SAMPLE_BITS-1:0];
    r.gain    = gain[15:0];
    r.is_open = gate_up;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      close_lvl = RST_CLOSE_THRESHOLD;
      open_lvl  = RST_OPEN_LEVEL;
      roll_f    = RST_ROLLOFF_FACTOR;
      atk_c     = RST_ATTACK_COEFF;
      rel_c     = RST_RELEASE_COEFF;
      env_lvl   = '0;
      last_gain = UNITY_Q15;
      gate_up   = 1'b1;
      gated_q.delete();
      errs      = 0;
      seen      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (gated_q.size() == 0) begin
          errs++;
          $error("result with no sample waiting: sample_out %0d gain_now %0d",
                 out_sample_out, out_gain_now);
        end else begin
          want = gated_q.pop_front();
          if (out_sample_out !== $signed(want.sample)) begin
            errs++;
            $error("sample_out expected %0d actual %0d",
                   $signed(want.sample), out_sample_out);
          end
          if (out_gain_now !== want.gain) begin
            errs++;
            $error("gain_now expected %0d actual %0d", want.gain, out_gain_now);
          end
          if (out_gate_open !== want.is_open) begin
            errs++;
            $error("gate_open expected %0d actual %0d", want.is_open, out_gate_open);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CLOSE_THRESHOLD: close_lvl = cfg_wdata;
          CFG_OPEN_LEVEL:      open_lvl  = cfg_wdata;
          CFG_ROLLOFF_FACTOR:  roll_f    = cfg_wdata;
          CFG_ATTACK_COEFF:    atk_c     = cfg_wdata;
          CFG_RELEASE_COEFF:   rel_c     = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        gated_q.push_back(gate_step(in_sample_in));
    end
    mismatches   <= errs;
    pending      <= gated_q.size();
    results_seen <= seen;
  end

endmodule

>>> sim/audio_noise_gate_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_noise_gate_test: top level of the noise gate simulation
// drives sample requests and register settings, stalls the result side at
// random and once for a long stretch, and reports the checker's verdict
// ----------------------------------------------------------------------------
module audio_noise_gate_test
  import ang_pkg::*;
;

  // cycles in which no request moves on either side before the run is called hung
  localparam int STALL_LIMIT = 5000;
  // length of the one long result hold-off
  localparam int HOLD_CYCLES = 300;
  // random samples per register setting, and number of random settings
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES      = 6;

  typedef enum int {SEG_LOUD, SEG_QUIET, SEG_SILENT, SEG_EDGE} seg_kind_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic [15:0]                   out_gain_now;
  logic                          out_gate_open;
  logic                          cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [15:0]                   cfg_wdata = '0;

  // checker status
  int mismatches, pending, results_seen;

  // stimulus bookkeeping
  int   samples_sent = 0;
  int   settings_used = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  logic calm = 1'b0;          // no idling on either side while set
  logic squeeze = 1'b0;       // asks the result side for its long hold-off
  logic squeeze_done = 1'b0;

  audio_noise_gate u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_gain_now   (out_gain_now),
    .out_gate_open  (out_gate_open),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  gate_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_gain_now   (out_gain_now),
    .out_gate_open  (out_gate_open),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_seen   (results_seen)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // result side: random stalls, one long hold-off on request, none while calm
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (squeeze && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left    = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 23);
    end
  end

  // watchdog: counts cycles in which neither channel moves a request
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("[audio_noise_gate] ERROR");
        $finish;
      end
    end
  end

  // one sample request, with a random gap in front of it unless calm
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  // drop valid and wait until every result is back and the datapath is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // all five registers, sometimes a write to an unused index as well
  task automatic load_settings(input logic [15:0] thr, input logic [15:0] lvl,
                               input logic [15:0] roll, input logic [15:0] atk,
                               input logic [15:0] rel);
    write_reg(CFG_CLOSE_THRESHOLD, thr);
    write_reg(CFG_OPEN_LEVEL, lvl);
    write_reg(CFG_ROLLOFF_FACTOR, roll);
    write_reg(CFG_ATTACK_COEFF, atk);
    write_reg(CFG_RELEASE_COEFF, rel);
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_RELEASE_COEFF) + 1,
                                          (1 << CFG_IDX_W) - 1)),
                16'($urandom));
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_extreme();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = 16'h0000;
      1:       v = 16'h0001;
      2:       v = UNITY_Q15;
      default: v = 16'hFFFF;
    endcase
    return v;
  endfunction

  // mostly settings a real gate would use, plus extremes and raw noise
  task automatic load_random_settings();
    logic [15:0] thr, lvl, roll, atk, rel;
    case ($urandom_range(0, 3))
      1: begin
        thr  = pick_extreme();
        lvl  = pick_extreme();
        roll = pick_extreme();
        atk  = pick_extreme();
        rel  = pick_extreme();
      end
      2: begin
        thr  = 16'($urandom);
        lvl  = 16'($urandom);
        roll = 16'($urandom);
        atk  = 16'($urandom);
        rel  = 16'($urandom);
      end
      default: begin
        thr  = 16'($urandom_range(0, 8000));
        lvl  = thr + 16'($urandom_range(0, 16000));
        roll = 16'($urandom);
        atk  = 16'($urandom_range(2000, 65535));
        rel  = 16'($urandom_range(50, 3000));
      end
    endcase
    load_settings(thr, lvl, roll, atk, rel);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input seg_kind_t kind);
    logic signed [SAMPLE_BITS-1:0] s;
    case (kind)
      SEG_LOUD:   s = SAMPLE_BITS'($urandom);
      SEG_QUIET:  s = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
      SEG_SILENT: s = '0;
      default: begin
        case ($urandom_range(0, 4))
          0:       s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          1:       s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          2:       s = '1;
          3:       s = SAMPLE_BITS'(1);
          default: s = '0;
        endcase
      end
    endcase
    return s;
  endfunction

  initial begin : stimulus
    int        phase;
    int        n;
    int        seg_len;
    seg_kind_t kind;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: full scale both ways, sign bit patterns, silence
    send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_sample('1);
    send_sample(SAMPLE_BITS'(1));
    send_sample({(SAMPLE_BITS/2){2'b01}});
    send_sample({(SAMPLE_BITS/2){2'b10}});
    send_sample('0);
    settle();
    settings_used++;

    // envelope forced to zero and open level at zero: the gate closes, then
    // sits exactly on the open level and gives zero gain
    load_settings(16'h0001, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_sample(SAMPLE_BITS'(12345));
    send_sample('1);
    settle();

    // close threshold at unity, full attack, no release: the gate flips
    // between open and decaying on every sample
    load_settings(UNITY_Q15, 16'h4000, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    send_sample('0);
    settle();

    // both levels above unity: the envelope never reaches them, so the gate
    // closes and stays closed
    load_settings(16'hFFFF, 16'hFFFF, 16'd40000, 16'd30000, 16'd3000);
    send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    send_sample(SAMPLE_BITS'(-20000));
    send_sample('0);
    send_sample(SAMPLE_BITS'(7));
    settle();

    // both levels at zero: any nonzero envelope reopens a closed gate at unity
    write_reg(CFG_IDX_W'(int'(CFG_RELEASE_COEFF) + 1), 16'hFFFF);
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'd20000, 16'd100);
    send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    send_sample(SAMPLE_BITS'(100));
    send_sample('0);
    settle();

    // random part: bursts of loud, quiet, silent and edge samples so the
    // envelope crosses the levels in both directions
    for (phase = 0; phase < PHASES; phase++) begin
      load_random_settings();
      if (phase == 1)
        squeeze <= 1'b1;          // long result hold-off while samples keep coming
      calm <= (phase == 3);       // one whole setting with no idling at all
      n = 0;
      while (n < PHASE_ITEMS) begin
        kind    = seg_kind_t'($urandom_range(0, 3));
        seg_len = $urandom_range(3, 40);
        while (seg_len > 0 && n < PHASE_ITEMS) begin
          send_sample(pick_sample(kind));
          seg_len--;
          n++;
        end
      end
      settle();
    end
    calm <= 1'b0;

    // drain and let the last result leave the block
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d samples sent under %0d register settings, %0d results checked",
             samples_sent, settings_used, results_seen);
    $display("including one %0d-cycle output hold-off with the input kept busy",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("[audio_noise_gate] OK");
    end else begin
      $display("[audio_noise_gate] ERROR");
    end
    $finish;
  end

endmodule
